### sv/dmc_pkg.sv
// Shared types, constants and helper functions for the two-axis damped motion controller.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package dmc_pkg;

  localparam int FRACTION_BITS    = 16;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int SEQUENCE_LENGTH  = 5;

  localparam int DATA_W    = 32;
  localparam int MODE_W    = 2;
  localparam int STEP_W    = 17;
  localparam int ITC_W     = 21;
  localparam int CFG_W     = 21;
  localparam int CFG_IDX_W = 2;
  localparam int SEQ_W     = 3;
  localparam int CORDIC_W  = 38;
  localparam int ANGLE_W   = 34;
  localparam int ITER_W    = 5;
  localparam int MUL_B_W   = 21;
  localparam int PROD_W    = DATA_W + MUL_B_W + 1;
  localparam int SUM_W     = 42;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INV_TAU    = CFG_IDX_W'(2);

  localparam logic [MODE_W-1:0] MODE_FOLLOW      = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_PRESET      = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_CONTROLLED  = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_PRESET_ALT  = MODE_W'(3);

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  localparam longint ONE_Q = longint'(1) << FRACTION_BITS;

  localparam logic signed [DATA_W-1:0] HEADING_TOL = DATA_W'((2 * ONE_Q + 50) / 100);
  localparam logic signed [DATA_W-1:0] FORWARD_TOL = DATA_W'((2 * ONE_Q + 5) / 10);
  localparam logic signed [CORDIC_W-1:0] COLUMN_CENTER = CORDIC_W'(60 * ONE_Q);
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = ANGLE_W'(64'sd1686629713);
  localparam logic signed [ANGLE_W-1:0] PI_Q30      = ANGLE_W'(64'sd3373259426);
  localparam int ANGLE_SHIFT = 30 - FRACTION_BITS;
  localparam logic signed [ANGLE_W-1:0] ANGLE_ROUND =
    ANGLE_W'(longint'(1) << (29 - FRACTION_BITS));
  localparam logic [ITER_W-1:0] ITER_LAST =
    ITER_W'((ANGLE_ITERATIONS < 30) ? (ANGLE_ITERATIONS - 1) : 29);

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'((ONE_Q + 500) / 1000);
  localparam logic [ITC_W-1:0]  ITC_RESET  = ITC_W'((ONE_Q + 5) / 10);

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] object_column;
    logic signed [DATA_W-1:0] object_depth;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_wheel_speed;
    logic signed [DATA_W-1:0] right_wheel_speed;
  } wheel_t;

  typedef struct packed {
    logic                       start;
    logic signed [CORDIC_W-1:0] vec_x;
    logic signed [CORDIC_W-1:0] vec_y;
  } cordic_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] angle;
  } cordic_res_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic [MUL_B_W-1:0]       b;
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_MUL_VH,
    ST_ERR,
    ST_MUL_EI,
    ST_MUL_VI,
    ST_DIFF,
    ST_MUL_HD,
    ST_VEL,
    ST_OUT
  } state_t;

  function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
    logic signed [ANGLE_W-1:0] r;
    case (i)
      5'd0:  r = ANGLE_W'(64'sd843314857);
      5'd1:  r = ANGLE_W'(64'sd497837829);
      5'd2:  r = ANGLE_W'(64'sd263043837);
      5'd3:  r = ANGLE_W'(64'sd133525159);
      5'd4:  r = ANGLE_W'(64'sd67021687);
      5'd5:  r = ANGLE_W'(64'sd33543516);
      5'd6:  r = ANGLE_W'(64'sd16775851);
      5'd7:  r = ANGLE_W'(64'sd8388437);
      5'd8:  r = ANGLE_W'(64'sd4194283);
      5'd9:  r = ANGLE_W'(64'sd2097149);
      5'd10: r = ANGLE_W'(64'sd1048576);
      5'd11: r = ANGLE_W'(64'sd524288);
      5'd12: r = ANGLE_W'(64'sd262144);
      5'd13: r = ANGLE_W'(64'sd131072);
      5'd14: r = ANGLE_W'(64'sd65536);
      5'd15: r = ANGLE_W'(64'sd32768);
      5'd16: r = ANGLE_W'(64'sd16384);
      5'd17: r = ANGLE_W'(64'sd8192);
      5'd18: r = ANGLE_W'(64'sd4096);
      5'd19: r = ANGLE_W'(64'sd2048);
      5'd20: r = ANGLE_W'(64'sd1024);
      5'd21: r = ANGLE_W'(64'sd512);
      5'd22: r = ANGLE_W'(64'sd256);
      5'd23: r = ANGLE_W'(64'sd128);
      5'd24: r = ANGLE_W'(64'sd64);
      5'd25: r = ANGLE_W'(64'sd32);
      5'd26: r = ANGLE_W'(64'sd16);
      5'd27: r = ANGLE_W'(64'sd8);
      5'd28: r = ANGLE_W'(64'sd4);
      5'd29: r = ANGLE_W'(64'sd2);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] preset_speed(input logic [SEQ_W-1:0] pos);
    logic signed [DATA_W-1:0] r;
    case (pos)
      3'd0:    r = DATA_W'(1 * ONE_Q);
      3'd1:    r = DATA_W'(2 * ONE_Q);
      3'd2:    r = DATA_W'(3 * ONE_Q);
      3'd3:    r = DATA_W'(4 * ONE_Q);
      3'd4:    r = '0;
      3'd5:    r = DATA_W'(5 * ONE_Q);
      3'd6:    r = DATA_W'(1 * ONE_Q);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = DATA_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = DATA_W'(SAT_LO);
    end else begin
      r = DATA_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/dmc_cordic.sv
// Iterative vectoring CORDIC: one rotation step per cycle on a shared add/shift datapath.
// Returns the heading angle of (vec_x, vec_y) in Q16.16; depends on dmc_pkg.
`default_nettype none
module dmc_cordic (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dmc_pkg::cordic_req_t req,
  output dmc_pkg::cordic_res_t      res
);

  logic busy;
  logic fin;
  logic done;
  logic [dmc_pkg::ITER_W-1:0] iter;
  logic signed [dmc_pkg::CORDIC_W-1:0] x;
  logic signed [dmc_pkg::CORDIC_W-1:0] y;
  logic signed [dmc_pkg::ANGLE_W-1:0] z;
  logic zero_vec;
  logic behind;
  logic signed [dmc_pkg::DATA_W-1:0] angle;

  logic signed [dmc_pkg::CORDIC_W-1:0] xs;
  logic signed [dmc_pkg::CORDIC_W-1:0] ys;
  logic signed [dmc_pkg::ANGLE_W-1:0] z_sel;
  logic signed [dmc_pkg::ANGLE_W-1:0] z_rnd;

  assign xs    = x >>> iter;
  assign ys    = y >>> iter;
  assign z_sel = behind ? dmc_pkg::PI_Q30 : z;
  assign z_rnd = (z_sel + dmc_pkg::ANGLE_ROUND) >>> dmc_pkg::ANGLE_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
      end else if (busy) begin
        if (iter == dmc_pkg::ITER_LAST) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      iter     <= '0;
      zero_vec <= (req.vec_x == '0) && (req.vec_y == '0);
      behind   <= (req.vec_x < 0) && (req.vec_y == '0);
      if (req.vec_x < 0) begin
        if (req.vec_y >= 0) begin
          x <= req.vec_y;
          y <= -req.vec_x;
          z <= dmc_pkg::HALF_PI_Q30;
        end else begin
          x <= -req.vec_y;
          y <= req.vec_x;
          z <= -dmc_pkg::HALF_PI_Q30;
        end
      end else begin
        x <= req.vec_x;
        y <= req.vec_y;
        z <= '0;
      end
    end else if (busy) begin
      iter <= iter + 1'b1;
      if (y >= 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + dmc_pkg::atan_q30(iter);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - dmc_pkg::atan_q30(iter);
      end
    end else if (fin) begin
      angle <= zero_vec ? '0 : dmc_pkg::DATA_W'(z_rnd);
    end
  end

  assign res.done  = done;
  assign res.angle = angle;

endmodule
`default_nettype wire

### sv/dmc_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
// Serves every product of the filter update; depends on dmc_pkg.
`default_nettype none
module dmc_mul (
  input  wire logic             clk,
  input  wire dmc_pkg::mul_op_t op,
  output logic signed [dmc_pkg::PROD_W-1:0] prod
);

  logic signed [dmc_pkg::MUL_B_W:0] b_ext;

  assign b_ext = $signed({1'b0, op.b});

  always_ff @(posedge clk) begin
    prod <= op.a * b_ext;
  end

endmodule
`default_nettype wire

### sv/two_axis_damped_motion_controller_top.sv
// Two-axis damped motion controller: sequencer, state registers and output register.
// Instantiates dmc_cordic and dmc_mul; depends on dmc_pkg.
//
// Usage: requests arrive on cmd (valid/ready). A measurement request (opcode 1)
// runs the heading CORDIC and may refresh the error estimates; it yields no
// result. A tick request (opcode 0) yields one wheel command on wheel
// (valid/ready), per drive_mode: follow, preset sequence, or controlled.
// A measurement runs the one-step-per-cycle CORDIC to completion. A follow
// or preset tick goes straight to the output state; a controlled tick runs
// its products in turn on the single shared multiplier, which does four products
// per axis. cmd_ready is high only in the idle state, so one request is in
// work at a time.
// The wheel output register holds a finished command while the receiver
// stalls; new requests are still taken, but a tick waits in its output state
// until the previous command has been taken.
// Reset (rst, synchronous) clears state, estimates, sequence position and
// restores the register defaults; no clearing pass is needed.
// Configuration is written through cfg_write/cfg_index/cfg_data, one cycle; index 3
// is ignored. The user must write only while the block is idle; it is not enforced.
`default_nettype none
module two_axis_damped_motion_controller_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [dmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dmc_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_ready,
  input  wire dmc_pkg::cmd_t                   cmd,
  output logic                                 wheel_valid,
  input  wire logic                            wheel_ready,
  output dmc_pkg::wheel_t                      wheel
);

  dmc_pkg::state_t state;
  dmc_pkg::state_t state_next;

  logic [dmc_pkg::MODE_W-1:0] drive_mode;
  logic [dmc_pkg::STEP_W-1:0] step_size;
  logic [dmc_pkg::ITC_W-1:0]  inv_tau;

  logic signed [dmc_pkg::DATA_W-1:0] fwd_vel;
  logic signed [dmc_pkg::DATA_W-1:0] turn_rate;
  logic signed [dmc_pkg::DATA_W-1:0] fwd_err;
  logic signed [dmc_pkg::DATA_W-1:0] head_err;
  logic [dmc_pkg::SEQ_W-1:0] seq_pos;

  logic signed [dmc_pkg::DATA_W-1:0] depth_hold;
  logic axis;
  logic signed [dmc_pkg::SUM_W-1:0] t1;
  logic signed [dmc_pkg::DATA_W-1:0] d;

  dmc_pkg::cordic_req_t cor_req;
  dmc_pkg::cordic_res_t cor_res;
  dmc_pkg::mul_op_t     mul_op;
  logic signed [dmc_pkg::PROD_W-1:0] prod;
  logic signed [dmc_pkg::SUM_W-1:0] fm;
  logic signed [dmc_pkg::DATA_W-1:0] err_cur;
  logic signed [dmc_pkg::DATA_W-1:0] vel_cur;
  logic signed [dmc_pkg::DATA_W-1:0] err_new;
  logic signed [dmc_pkg::DATA_W-1:0] vel_new;
  logic signed [dmc_pkg::DATA_W-1:0] v_preset;
  logic [dmc_pkg::SEQ_W:0] seq_inc;
  logic accept;
  logic out_load;
  logic is_preset;

  assign accept    = cmd_valid && cmd_ready;
  assign is_preset = drive_mode inside {dmc_pkg::MODE_PRESET, dmc_pkg::MODE_PRESET_ALT};
  assign fm        = dmc_pkg::SUM_W'(prod >>> dmc_pkg::FRACTION_BITS);
  assign err_cur   = axis ? fwd_err : head_err;
  assign vel_cur   = axis ? fwd_vel : turn_rate;
  assign err_new   = dmc_pkg::sat32(dmc_pkg::SUM_W'(err_cur) - fm);
  assign vel_new   = dmc_pkg::sat32(dmc_pkg::SUM_W'(vel_cur) + fm);
  assign v_preset  = dmc_pkg::preset_speed(seq_pos);
  assign seq_inc   = {1'b0, seq_pos} + 1'b1;

  assign cor_req.start = accept && (cmd.opcode == dmc_pkg::OP_MEASURE);
  assign cor_req.vec_x = dmc_pkg::CORDIC_W'(cmd.object_depth);
  assign cor_req.vec_y = dmc_pkg::COLUMN_CENTER - dmc_pkg::CORDIC_W'(cmd.object_column);

  dmc_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cor_req),
    .res (cor_res)
  );

  dmc_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    out_load   = 1'b0;
    mul_op.a   = vel_cur;
    mul_op.b   = dmc_pkg::MUL_B_W'(step_size);
    case (state)
      dmc_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.opcode == dmc_pkg::OP_MEASURE) begin
            state_next = dmc_pkg::ST_ANGLE;
          end else if (drive_mode == dmc_pkg::MODE_CONTROLLED) begin
            state_next = dmc_pkg::ST_MUL_VH;
          end else begin
            state_next = dmc_pkg::ST_OUT;
          end
        end
      end
      dmc_pkg::ST_ANGLE: begin
        if (cor_res.done) begin
          state_next = dmc_pkg::ST_IDLE;
        end
      end
      dmc_pkg::ST_MUL_VH: begin
        state_next = dmc_pkg::ST_ERR;
      end
      dmc_pkg::ST_ERR: begin
        state_next = dmc_pkg::ST_MUL_EI;
      end
      dmc_pkg::ST_MUL_EI: begin
        mul_op.a   = err_cur;
        mul_op.b   = inv_tau;
        state_next = dmc_pkg::ST_MUL_VI;
      end
      dmc_pkg::ST_MUL_VI: begin
        mul_op.a   = vel_cur;
        mul_op.b   = inv_tau;
        state_next = dmc_pkg::ST_DIFF;
      end
      dmc_pkg::ST_DIFF: begin
        state_next = dmc_pkg::ST_MUL_HD;
      end
      dmc_pkg::ST_MUL_HD: begin
        mul_op.a   = d;
        state_next = dmc_pkg::ST_VEL;
      end
      dmc_pkg::ST_VEL: begin
        state_next = axis ? dmc_pkg::ST_OUT : dmc_pkg::ST_MUL_VH;
      end
      dmc_pkg::ST_OUT: begin
        if (!wheel_valid || wheel_ready) begin
          out_load   = 1'b1;
          state_next = dmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dmc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode <= dmc_pkg::MODE_FOLLOW;
      step_size  <= dmc_pkg::STEP_RESET;
      inv_tau    <= dmc_pkg::ITC_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dmc_pkg::REG_DRIVE_MODE: drive_mode <= cfg_data[dmc_pkg::MODE_W-1:0];
        dmc_pkg::REG_STEP_SIZE:  step_size  <= cfg_data[dmc_pkg::STEP_W-1:0];
        dmc_pkg::REG_INV_TAU:    inv_tau    <= cfg_data[dmc_pkg::ITC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_vel     <= '0;
      turn_rate   <= '0;
      fwd_err     <= '0;
      head_err    <= '0;
      seq_pos     <= '0;
      axis        <= 1'b0;
      wheel_valid <= 1'b0;
    end else begin
      if (out_load) begin
        wheel_valid <= 1'b1;
      end else if (wheel_ready) begin
        wheel_valid <= 1'b0;
      end
      case (state)
        dmc_pkg::ST_IDLE: begin
          axis <= 1'b0;
        end
        dmc_pkg::ST_ANGLE: begin
          if (cor_res.done) begin
            if ((head_err > -dmc_pkg::HEADING_TOL) && (head_err < dmc_pkg::HEADING_TOL)) begin
              head_err <= cor_res.angle;
            end
            if ((fwd_err > -dmc_pkg::FORWARD_TOL) && (fwd_err < dmc_pkg::FORWARD_TOL)) begin
              fwd_err <= depth_hold;
            end
          end
        end
        dmc_pkg::ST_ERR: begin
          if (axis) begin
            fwd_err <= err_new;
          end else begin
            head_err <= err_new;
          end
        end
        dmc_pkg::ST_VEL: begin
          if (axis) begin
            fwd_vel <= vel_new;
          end else begin
            turn_rate <= vel_new;
          end
          axis <= 1'b1;
        end
        dmc_pkg::ST_OUT: begin
          if (out_load && is_preset) begin
            seq_pos <= (seq_inc >= (dmc_pkg::SEQ_W + 1)'(dmc_pkg::SEQUENCE_LENGTH)) ?
                       '0 : seq_inc[dmc_pkg::SEQ_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      depth_hold <= cmd.object_depth;
    end
    if (state == dmc_pkg::ST_MUL_VI) begin
      t1 <= fm;
    end
    if (state == dmc_pkg::ST_DIFF) begin
      d <= dmc_pkg::sat32(t1 - (fm <<< 1));
    end
    if (out_load) begin
      if (is_preset) begin
        wheel.left_wheel_speed  <= -v_preset;
        wheel.right_wheel_speed <= v_preset;
      end else begin
        wheel.left_wheel_speed  <= dmc_pkg::sat32(dmc_pkg::SUM_W'(turn_rate) -
                                                  dmc_pkg::SUM_W'(fwd_vel));
        wheel.right_wheel_speed <= dmc_pkg::sat32(dmc_pkg::SUM_W'(fwd_vel) +
                                                  dmc_pkg::SUM_W'(turn_rate));
      end
    end
  end

endmodule
`default_nettype wire

### sv/dmc_checker.sv
// Port-level checker for the two-axis damped motion controller, bound to the top level.
// Depends on dmc_pkg and two_axis_damped_motion_controller_top.
`default_nettype none
module dmc_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          cmd_valid,
  input wire logic                          cmd_ready,
  input wire logic                          wheel_valid,
  input wire logic                          wheel_ready,
  input wire dmc_pkg::wheel_t               wheel
);

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !wheel_valid)
    else $error("wheel_valid high after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("request taken while previous request still in work");

  a_wheel_valid_holds: assert property (@(posedge clk) disable iff (rst)
    wheel_valid && !wheel_ready |=> wheel_valid)
    else $error("wheel command dropped before it was taken");

  a_wheel_payload_holds: assert property (@(posedge clk) disable iff (rst)
    wheel_valid && !wheel_ready |=> $stable(wheel))
    else $error("wheel command changed while stalled");

endmodule

bind two_axis_damped_motion_controller_top dmc_checker u_dmc_checker (.*);
`default_nettype wire
